// ===== src/pcg_pkg.sv =====
// Shared types and constants for the PCG32 bounded generator.
package pcg_pkg;

	localparam logic [63:0] LCG_MULT    = 64'h5851_F42D_4C95_7F2D;
	localparam logic [63:0] STATE_RESET = 64'h853C_49E6_748F_EA9B;
	localparam logic [63:0] INCR_RESET  = 64'hDA3E_39CB_94B9_5BDB;

	// Operation codes carried by an input item.
	typedef enum logic [1:0] {
		OP_RAW     = 2'd0,
		OP_BOUNDED = 2'd1,
		OP_RESEED  = 2'd2
	} op_t;

	// Configuration register indexes.
	localparam logic REG_SEED   = 1'b0;
	localparam logic REG_STREAM = 1'b1;

	// Status of a multi-cycle arithmetic unit; done pulses once the result is held.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

	// XSH-RR output permutation of a 64-bit state.
	function automatic logic [31:0] pcg_out(input logic [63:0] s);
		logic [63:0] xs;
		logic [31:0] mixed;
		logic [4:0]  turn;
		logic [63:0] dbl;
		xs    = (s >> 18) ^ s;
		mixed = xs[58:27];
		turn  = s[63:59];
		dbl   = {mixed, mixed} >> turn;
		return dbl[31:0];
	endfunction

endpackage

// ===== src/pcg_mul.sv =====
// Iterative LCG multiply-add: product = a * LCG_MULT + addend, 16 multiplier bits a cycle.
module pcg_mul (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [63:0]           a,
	input  logic [63:0]           addend,
	output pcg_pkg::unit_status_t status,
	output logic [63:0]           product
);
	import pcg_pkg::*;

	logic [63:0] acc_q;
	logic [63:0] a_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [15:0] digit;
	logic [79:0] pp;

	assign digit = LCG_MULT[{cnt_q, 4'b0000} +: 16];
	assign pp    = a_q * digit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			a_q    <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				acc_q  <= addend;
				a_q    <= a;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				acc_q <= acc_q + pp[63:0];
				a_q   <= a_q << 16;
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign product     = acc_q;

endmodule

// ===== src/pcg_div.sv =====
// Restoring 32-bit remainder unit, one quotient bit a cycle.
module pcg_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [31:0]           dividend,
	input  logic [31:0]           divisor,
	output pcg_pkg::unit_status_t status,
	output logic [31:0]           remainder
);
	import pcg_pkg::*;

	logic [31:0] dvd_q;
	logic [31:0] dvs_q;
	logic [31:0] rem_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] shifted;
	logic [32:0] diff;

	assign shifted = {rem_q, dvd_q[31]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q  <= '0;
			dvs_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dvd_q  <= dividend;
				dvs_q  <= divisor;
				rem_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// no borrow: shifted partial remainder >= divisor
				rem_q <= diff[32] ? shifted[31:0] : diff[31:0];
				dvd_q <= dvd_q << 1;
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign remainder   = rem_q;

endmodule

// ===== src/pcg32_generator_bounded.sv =====
// PCG32 XSH-RR generator with raw draw, bounded draw and reseed operations.
// Raw draw: the 64-bit LCG step runs on a shared multiplier, 16 bits a cycle.
// Bounded draw: the rejection threshold, one LCG step per attempt, then the final
// remainder; threshold and remainder run on one 1-bit-a-cycle divider. Reseed: two steps.
// One item in flight, next accept in the cycle after the result loads; reset loads the
// fixed state/increment and clears seed/stream.
module pcg32_generator_bounded (
	input  logic        clk,
	input  logic        arst_n,
	// input item channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] bound,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] value,
	output logic        bad_bound,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);
	import pcg_pkg::*;

	// Sequencer states.
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_THRESH = 6'b000010,  // divider computes (2^32 - bound) mod bound
		ST_KICK   = 6'b000100,  // latch permuted output, launch LCG step
		ST_STEP   = 6'b001000,  // wait for the multiplier
		ST_REM    = 6'b010000,  // divider computes draw mod bound
		ST_DONE   = 6'b100000   // move result to the output register
	} state_t;

	state_t      state_q;

	// Generator state and configuration registers.
	logic [63:0] gen_state_q;
	logic [63:0] gen_inc_q;
	logic [63:0] seed_q;
	logic [62:0] stream_q;

	// Per-item working registers.
	op_t         op_q;
	logic [31:0] bound_q;
	logic [31:0] thresh_q;
	logic [31:0] draw_q;
	logic        phase_q;   // reseed: second step pending
	logic [31:0] res_q;
	logic        flag_q;

	// Output register.
	logic        out_valid_q;
	logic [31:0] value_q;
	logic        bad_bound_q;

	// Shared units.
	unit_status_t mul_st;
	unit_status_t div_st;
	logic [63:0]  mul_prod;
	logic [31:0]  div_rem;
	logic         mul_start;
	logic         div_start;
	logic [31:0]  div_dvd;
	logic [31:0]  div_dvs;
	logic [63:0]  seed_add;
	logic         in_xfer;
	logic         out_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign mul_start = (state_q == ST_KICK);

	// After the first reseed step the seed is folded into the new state.
	assign seed_add = (op_q == OP_RESEED && !phase_q) ? seed_q : '0;

	// Divider launch: threshold on accept of a bounded draw with a nonzero bound,
	// remainder once a draw clears the threshold.
	always_comb begin
		div_start = 1'b0;
		div_dvd   = draw_q;
		div_dvs   = bound_q;
		if (in_xfer && operation == OP_BOUNDED && bound != '0) begin
			div_start = 1'b1;
			div_dvd   = 32'd0 - bound;
			div_dvs   = bound;
		end else if (state_q == ST_STEP && mul_st.done && op_q == OP_BOUNDED
			&& draw_q >= thresh_q) begin
			div_start = 1'b1;
		end
	end

	pcg_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (gen_state_q),
		.addend  (gen_inc_q),
		.status  (mul_st),
		.product (mul_prod)
	);

	pcg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.status    (div_st),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gen_state_q <= STATE_RESET;
			gen_inc_q   <= INCR_RESET;
			seed_q      <= '0;
			stream_q    <= '0;
			op_q        <= OP_RAW;
			bound_q     <= '0;
			thresh_q    <= '0;
			draw_q      <= '0;
			phase_q     <= 1'b0;
			res_q       <= '0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			bad_bound_q <= 1'b0;
		end else begin
			// configuration transfers; the user must issue them only while the block is idle (not enforced here)
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SEED:   seed_q   <= cfg_data;
					REG_STREAM: stream_q <= cfg_data[62:0];
					default:    ;
				endcase
			end

			// output register: load wins over the drain of the previous result
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						op_q    <= op_t'(operation);
						bound_q <= bound;
						phase_q <= 1'b0;
						res_q   <= '0;
						flag_q  <= 1'b0;
						case (operation)
							OP_RAW: begin
								state_q <= ST_KICK;
							end
							OP_BOUNDED: begin
								if (bound == '0) begin
									flag_q  <= 1'b1;
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_THRESH;
								end
							end
							OP_RESEED: begin
								gen_state_q <= '0;
								gen_inc_q   <= {stream_q, 1'b1};
								state_q     <= ST_KICK;
							end
							default: begin
								// unused code: no state change, zero result
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_THRESH: begin
					if (div_st.done) begin
						thresh_q <= div_rem;
						state_q  <= ST_KICK;
					end
				end
				ST_KICK: begin
					draw_q  <= pcg_out(gen_state_q);
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (mul_st.done) begin
						gen_state_q <= mul_prod + seed_add;
						case (op_q)
							OP_RAW: begin
								res_q   <= draw_q;
								state_q <= ST_DONE;
							end
							OP_BOUNDED: begin
								// reject draws under the threshold, each costs a step
								state_q <= (draw_q < thresh_q) ? ST_KICK : ST_REM;
							end
							OP_RESEED: begin
								if (!phase_q) begin
									phase_q <= 1'b1;
									state_q <= ST_KICK;
								end else begin
									state_q <= ST_DONE;
								end
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_REM: begin
					if (div_st.done) begin
						res_q   <= div_rem;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// output register may still hold the previous result
					if (out_load) begin
						value_q     <= res_q;
						bad_bound_q <= flag_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign bad_bound = bad_bound_q;

	// The multiplier only runs while the sequencer waits on it.
	a_mul_owned: assert property (@(posedge clk) disable iff (!arst_n)
		mul_st.busy |-> state_q == ST_STEP)
		else $error("multiplier busy outside step state");

	// The divider only runs for the threshold or the final remainder.
	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.busy |-> (state_q == ST_THRESH || state_q == ST_REM))
		else $error("divider busy outside threshold/remainder states");

	// A flagged bound always comes with a zero value.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_bound) |-> value == '0)
		else $error("bad bound result with nonzero value");

	// The LCG increment stays odd through reset and reseeds.
	a_inc_odd: assert property (@(posedge clk) disable iff (!arst_n)
		gen_inc_q[0])
		else $error("LCG increment became even");

endmodule

// ===== verif/tb_pcg32_generator_bounded.sv =====
// Self-checking testbench for the PCG32 XSH-RR generator with bounded draws and reseed.
`timescale 1ns / 100ps

module tb_pcg32_generator_bounded;
	import pcg_pkg::*;

	// The package enum stops at reseed; code 3 is legal on the port and must be ignored.
	localparam logic [1:0]  OP_UNUSED  = 2'd3;
	localparam logic [63:0] MULTIPLIER = 64'd6364136223846793005;
	localparam int          CHUNKS     = 8;
	localparam int          CHUNK_LEN  = 50;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] lim;
	} gen_request_t;

	typedef struct {
		logic [31:0] value;
		logic        bad;
	} draw_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = '0;
	logic [31:0] bound = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] value;
	logic        bad_bound;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [63:0] cfg_data = '0;

	// Predictor copy of the generator and its registers.
	logic [63:0] rng_state = STATE_RESET;
	logic [63:0] rng_incr  = INCR_RESET;
	logic [63:0] seed_reg  = '0;
	logic [62:0] stream_reg = '0;

	gen_request_t pending_requests[$];
	draw_t        expected_draws[$];
	gen_request_t next_req;
	draw_t        head_draw;
	int           send_gap = 0;
	int           stall_left = 0;
	int           fail_count = 0;
	bit           quiet = 1'b0;   // no gaps or stalls while set

	pcg32_generator_bounded dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.bound     (bound),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.bad_bound (bad_bound),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// One LCG step: returns the XSH-RR permutation of the old state.
	function automatic logic [31:0] lcg_draw();
		logic [63:0] old;
		logic [63:0] xs;
		logic [31:0] mixed;
		logic [4:0]  rot;
		old = rng_state;
		rng_state = old * MULTIPLIER + rng_incr;
		xs = ((old >> 18) ^ old) >> 27;
		mixed = xs[31:0];
		rot = old[63:59];
		return (mixed >> rot) | (mixed << ((6'd32 - {1'b0, rot}) & 6'd31));
	endfunction

	// Works out the result of one accepted request and queues it.
	function automatic void predict_draw(logic [1:0] op, logic [31:0] lim);
		draw_t       want;
		logic [31:0] floor_v;
		logic [31:0] d;
		want.value = '0;
		want.bad = 1'b0;
		case (op)
			OP_RAW: want.value = lcg_draw();
			OP_BOUNDED: begin
				if (lim == 32'd0) begin
					// zero bound: flagged, state untouched
					want.bad = 1'b1;
				end else begin
					// reject draws below (2^32 - lim) mod lim; each try costs a step
					floor_v = (32'd0 - lim) % lim;
					do
						d = lcg_draw();
					while (d < floor_v);
					want.value = d % lim;
				end
			end
			OP_RESEED: begin
				rng_state = '0;
				rng_incr = {stream_reg, 1'b1};
				d = lcg_draw();
				rng_state = rng_state + seed_reg;
				d = lcg_draw();
			end
			default: ;   // unused code: no state change, zero result
		endcase
		expected_draws.push_back(want);
	endfunction

	// Mostly back-to-back, some short gaps, a few long ones.
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void queue_request(logic [1:0] op, logic [31:0] lim);
		gen_request_t req;
		req.op = op;
		req.lim = lim;
		pending_requests.push_back(req);
	endfunction

	// Random mix; bounds lean toward the small and toward the high-rejection region.
	function automatic void queue_random_request();
		int          r;
		logic [31:0] lim;
		r = $urandom_range(0, 99);
		case ($urandom_range(0, 3))
			0: lim = $urandom_range(1, 20);
			1: lim = $urandom();
			2: lim = 32'h7FFF_FFFF + $urandom_range(0, 3);
			default: lim = 32'hFFFF_FFFF - $urandom_range(0, 15);
		endcase
		if (r < 40)
			queue_request(OP_RAW, $urandom());
		else if (r < 80)
			queue_request(OP_BOUNDED, lim);
		else if (r < 84)
			queue_request(OP_BOUNDED, 32'd0);
		else if (r < 94)
			queue_request(OP_RESEED, $urandom());
		else
			queue_request(OP_UNUSED, $urandom());
	endfunction

	// Checked at the falling edge so that all transfers of the cycle have settled.
	task automatic wait_idle();
		@(negedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_draws.size() != 0)
			@(negedge clk);
	endtask

	// Register write; only called with the block idle.
	task automatic write_reg(input logic idx, input logic [63:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_SEED)
			seed_reg = data;
		else
			stream_reg = data[62:0];   // top bit of the data is dropped
	endtask

	// Request driver: predicts on each transfer, then loads the next request after a gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= '0;
			bound <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				predict_draw(operation, bound);
			// valid holds with its payload until the transfer
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_requests.size() != 0) begin
					next_req = pending_requests.pop_front();
					in_valid <= 1'b1;
					operation <= next_req.op;
					bound <= next_req.lim;
					send_gap <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compares each transfer with the oldest prediction, stalls at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_draws.size() == 0) begin
					$display("%0t: unexpected result value %h bad_bound %b",
						$time, value, bad_bound);
					fail_count++;
				end else begin
					head_draw = expected_draws.pop_front();
					if (value !== head_draw.value) begin
						$display("%0t: value mismatch: expected %h, got %h",
							$time, head_draw.value, value);
						fail_count++;
					end
					if (bad_bound !== head_draw.bad) begin
						$display("%0t: bad_bound mismatch: expected %b, got %b",
							$time, head_draw.bad, bad_bound);
						fail_count++;
					end
				end
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left <= pick_gap();
			end
		end
	end

	// Run limit, far above the slowest legal run.
	initial begin
		#(10_000_000);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset configuration: field extremes, every operation, zero bound, unused code.
		queue_request(OP_RAW, 32'd0);
		queue_request(OP_RAW, 32'hFFFF_FFFF);
		queue_request(OP_UNUSED, 32'd0);
		queue_request(OP_UNUSED, 32'hFFFF_FFFF);
		queue_request(OP_BOUNDED, 32'd0);
		queue_request(OP_BOUNDED, 32'd1);
		queue_request(OP_BOUNDED, 32'd2);
		queue_request(OP_BOUNDED, 32'd3);
		queue_request(OP_BOUNDED, 32'h7FFF_FFFF);
		queue_request(OP_BOUNDED, 32'h8000_0000);
		queue_request(OP_BOUNDED, 32'h8000_0001);   // close to half the draws rejected
		queue_request(OP_BOUNDED, 32'hFFFF_FFFE);
		queue_request(OP_BOUNDED, 32'hFFFF_FFFF);
		queue_request(OP_RESEED, 32'd0);             // reseed with seed 0, stream 0
		queue_request(OP_RAW, 32'd0);
		queue_request(OP_BOUNDED, 32'd10);
		wait_idle();

		// All-ones on both registers; the stream loses its top bit.
		write_reg(REG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_STREAM, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_request(OP_RESEED, 32'h5555_5555);
		queue_request(OP_RAW, 32'hAAAA_AAAA);
		queue_request(OP_BOUNDED, 32'h8000_0001);
		queue_request(OP_BOUNDED, 32'd6);
		wait_idle();

		write_reg(REG_SEED, 64'd0);
		write_reg(REG_STREAM, 64'd0);
		queue_request(OP_RESEED, 32'd0);
		queue_request(OP_RAW, 32'd0);
		queue_request(OP_RAW, 32'd0);
		wait_idle();

		// Random chunks; each boundary drains the block, and most carry a new configuration.
		for (int c = 0; c < CHUNKS; c++) begin
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_SEED, {$urandom(), $urandom()});
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_STREAM, {$urandom(), $urandom()});
			quiet = (c == 3);
			queue_request(OP_RESEED, $urandom());
			for (int i = 0; i < CHUNK_LEN; i++)
				queue_random_request();
			wait_idle();
		end
		quiet = 1'b0;

		// Let any stray result show up before the verdict.
		repeat (200) @(posedge clk);
		if (fail_count == 0 && expected_draws.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
